// ===== rtl/ifa_pkg.sv =====
// Shared types and constants for the IMU frame assembler.
`default_nettype none
package ifa_pkg;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 7;
    localparam int IDX_W     = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_HEAD     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INS_CODE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATT_CODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INS_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ATT_LEN  = 3'd5;

    localparam logic [BYTE_W-1:0] HEAD_RST     = 8'hFC;
    localparam logic [BYTE_W-1:0] TAIL_RST     = 8'hFD;
    localparam logic [BYTE_W-1:0] INS_CODE_RST = 8'h40;
    localparam logic [BYTE_W-1:0] ATT_CODE_RST = 8'h41;
    localparam logic [LEN_W-1:0]  INS_LEN_RST  = 7'd64;
    localparam logic [LEN_W-1:0]  ATT_LEN_RST  = 7'd56;

    localparam logic KIND_INERTIAL = 1'b0;
    localparam logic KIND_ATTITUDE = 1'b1;

    typedef struct packed {
        logic             start;
        logic             kind;
        logic [LEN_W-1:0] len;
    } t_pkt_cmd;

endpackage
`default_nettype wire

// ===== rtl/ifa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ifa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ifa_replay.sv =====
// Packet replay: reads a validated frame out of the buffer, one word per cycle while the output is not stalled.
`default_nettype none
module ifa_replay #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ifa_pkg::t_pkt_cmd            i_cmd,
    output logic                              o_busy,
    output logic                              o_rd_en,
    output logic [$clog2(MAX_LEN)-1:0]        o_rd_addr,
    input  wire logic [ifa_pkg::BYTE_W-1:0]   i_rd_data,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic                              o_packet_kind,
    output logic [ifa_pkg::IDX_W-1:0]         o_byte_index,
    output logic [ifa_pkg::BYTE_W-1:0]        o_packet_byte,
    output logic                              o_last_of_packet
);
    import ifa_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int KW = (AW > LEN_W) ? AW : LEN_W;

    logic             r_active;
    logic [LEN_W-1:0] r_k;
    logic [LEN_W-1:0] r_len;
    logic             r_kind;

    logic             r_rd_vld;
    logic             r_rd_kind;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_last;

    logic              r_out_valid;
    logic              r_out_kind;
    logic [IDX_W-1:0]  r_out_idx;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic             adv;
    logic             issue;
    logic [LEN_W-1:0] n_k;
    logic             k_last;
    logic [KW-1:0]    k_ext;

    assign adv    = !r_out_valid || !i_out_stall;
    assign issue  = r_active && (!r_rd_vld || adv);
    assign n_k    = r_k + LEN_W'(1);
    assign k_last = (n_k == r_len);
    assign k_ext  = KW'(r_k);

    assign o_busy    = r_active;
    assign o_rd_en   = issue;
    assign o_rd_addr = k_ext[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start && !r_active) begin
                r_active <= 1'b1;
            end else if (issue && k_last) begin
                r_active <= 1'b0;
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
            end else if (adv) begin
                r_rd_vld <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_rd_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !r_active) begin
            r_k    <= '0;
            r_len  <= i_cmd.len;
            r_kind <= i_cmd.kind;
        end else if (issue) begin
            r_k <= n_k;
        end
        if (issue) begin
            r_rd_kind <= r_kind;
            r_rd_idx  <= r_k[IDX_W-1:0];
            r_rd_last <= k_last;
        end
        if (adv && r_rd_vld) begin
            r_out_kind <= r_rd_kind;
            r_out_idx  <= r_rd_idx;
            r_out_byte <= i_rd_data;
            r_out_last <= r_rd_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_packet_kind    = r_out_kind;
    assign o_byte_index     = r_out_idx;
    assign o_packet_byte    = r_out_byte;
    assign o_last_of_packet = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/imu_frame_assembler_unit.sv =====
// IMU frame assembler: head/tail delimited frame receiver with packet replay.
// Received words are accepted without stalls while no replay is busy; the first word of a
//   completed packet passes the replay start, buffer read and output registers.
// Input stall: a completed packet of length L holds off input while its L words are read, and
//   longer while the output stalls with the replay pipe full; set by the single buffer read port.
// Reset: synchronous, active low; clears framing state and loads register
//   defaults. The frame buffer is not cleared.
`default_nettype none
module imu_frame_assembler_unit #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [ifa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [ifa_pkg::BYTE_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [ifa_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic                                   o_packet_kind,
    output logic [ifa_pkg::IDX_W-1:0]              o_byte_index,
    output logic [ifa_pkg::BYTE_W-1:0]             o_packet_byte,
    output logic                                   o_last_of_packet
);
    import ifa_pkg::*;

    localparam int AW    = $clog2(MAX_LEN);
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [BYTE_W-1:0] r_head, r_tail, r_ins_code, r_att_code;
    logic [LEN_W-1:0]  r_ins_len, r_att_len;

    logic [BYTE_W-1:0] r_prev, n_prev;
    logic              r_in_frame, n_in_frame;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_type, n_type;
    logic [BYTE_W-1:0] r_last, n_last;

    logic              in_acc;
    logic              opens;
    logic [CW-1:0]     max_len, bound, cnt, nc, ins_len, att_len;
    logic              store;
    logic              ins_done, att_done;
    logic              we;
    logic [AW-1:0]     waddr;
    logic              busy;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    t_pkt_cmd          cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= HEAD_RST;
            r_tail     <= TAIL_RST;
            r_ins_code <= INS_CODE_RST;
            r_att_code <= ATT_CODE_RST;
            r_ins_len  <= INS_LEN_RST;
            r_att_len  <= ATT_LEN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_HEAD:     r_head     <= i_cfg_data;
                REG_TAIL:     r_tail     <= i_cfg_data;
                REG_INS_CODE: r_ins_code <= i_cfg_data;
                REG_ATT_CODE: r_att_code <= i_cfg_data;
                REG_INS_LEN:  r_ins_len  <= i_cfg_data[LEN_W-1:0];
                REG_ATT_LEN:  r_att_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = busy;

    assign opens   = (r_prev == r_tail) && (i_rx_byte == r_head);
    assign ins_len = CW'(r_ins_len);
    assign att_len = CW'(r_att_len);
    assign max_len = (ins_len > att_len) ? ins_len : att_len;
    assign bound   = (max_len > CW'(MAX_LEN)) ? CW'(MAX_LEN) : max_len;
    assign cnt     = CW'(r_count);
    assign store   = r_in_frame && (cnt < bound);
    assign nc      = CW'(n_count);

    assign ins_done = (ins_len >= CW'(2)) && (ins_len <= bound) && (nc == ins_len);
    assign att_done = (att_len >= CW'(2)) && (att_len <= bound) && (nc == att_len);

    always_comb begin
        n_prev     = r_prev;
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_type     = r_type;
        n_last     = r_last;
        we         = 1'b0;
        waddr      = '0;
        cmd        = '0;
        if (in_acc) begin
            n_prev = i_rx_byte;
            if (store) begin
                we      = 1'b1;
                waddr   = r_count[AW-1:0];
                n_count = r_count + CNT_W'(1);
                n_last  = i_rx_byte;
                if (cnt == CW'(1)) begin
                    n_type = i_rx_byte;
                end
            end else if (opens) begin
                we         = 1'b1;
                n_in_frame = 1'b1;
                n_count    = CNT_W'(1);
                n_last     = i_rx_byte;
            end else if (r_in_frame) begin
                n_in_frame = 1'b0;
            end
            // completion test only applies to words taken while in a frame
            if (r_in_frame && (nc >= CW'(2))) begin
                priority if (n_type == r_ins_code && ins_done) begin
                    n_in_frame = 1'b0;
                    cmd.start  = (n_last == r_tail);
                    cmd.kind   = KIND_INERTIAL;
                    cmd.len    = r_ins_len;
                end else if (n_type == r_att_code && att_done) begin
                    n_in_frame = 1'b0;
                    cmd.start  = (n_last == r_tail);
                    cmd.kind   = KIND_ATTITUDE;
                    cmd.len    = r_att_len;
                end else begin
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_in_frame <= 1'b0;
            r_count    <= '0;
        end else begin
            r_prev     <= n_prev;
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
        r_last <= n_last;
    end

    ifa_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_LEN)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    ifa_replay #(
        .MAX_LEN (MAX_LEN)
    ) u_replay (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_busy           (busy),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_packet_kind    (o_packet_kind),
        .o_byte_index     (o_byte_index),
        .o_packet_byte    (o_packet_byte),
        .o_last_of_packet (o_last_of_packet)
    );

endmodule
`default_nettype wire
